@@ src/smc_pkg.sv @@
package smc_pkg;

    // Fixed field widths
    localparam int unsigned VOLT_W  = 16;
    localparam int unsigned CUR_W   = 24;
    localparam int unsigned RANGE_W = 3;
    localparam int unsigned TEMP_W  = 8;
    localparam int unsigned RES_W   = 20;

    // Ring sum covers up to sixteen 16-bit samples
    localparam int unsigned SUM_W = 20;

    // Scaled average (average * 1000) and the divider quotient
    localparam int unsigned DIV_W = 26;

    localparam logic [VOLT_W-1:0] VOLT_ERROR       = 16'hFFFF;
    localparam logic [TEMP_W-1:0] TEMP_ERROR       = 8'h7F;
    localparam logic [9:0]        MV_TO_UV         = 10'd1000;
    localparam logic [RES_W-1:0]  RESISTANCE_RESET = 20'd998000;

    // One classified measurement set on its way to the back end
    typedef struct packed {
        logic               has_sample;
        logic [SUM_W-1:0]   sum;
        logic [CUR_W-1:0]   load;
        logic [RANGE_W-1:0] range;
        logic [VOLT_W-1:0]  supply;
        logic [TEMP_W-1:0]  temp_code;
    } smc_entry_t;

endpackage

@@ src/smc_front.sv @@
module smc_front
    import smc_pkg::*;
#(
    parameter int unsigned AVERAGE_DEPTH = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [VOLT_W-1:0]  vout_sample_mv,
    input  logic               vout_sample_valid,
    input  logic [CUR_W-1:0]   load_current_ua,
    input  logic [RANGE_W-1:0] sensor_range,
    input  logic [VOLT_W-1:0]  supply_sample_mv,
    input  logic               supply_sample_valid,
    input  logic [TEMP_W-1:0]  temperature_c,
    input  logic               temperature_valid,
    output smc_entry_t         entry
);

    localparam int unsigned IDX_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AVERAGE_DEPTH - 1);

    logic [VOLT_W-1:0] ring_reg [AVERAGE_DEPTH];
    logic [IDX_W-1:0]  widx_reg;
    logic [IDX_W-1:0]  widx_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [TEMP_W-1:0] temp_mag;
    logic [TEMP_W-1:0] temp_code;

    // Swap the oldest sample for the new one in the running sum
    always_comb
    begin
        sum_next  = sum_reg - SUM_W'(ring_reg[widx_reg]) + SUM_W'(vout_sample_mv);
        widx_next = (widx_reg == LAST_IDX) ? '0 : widx_reg + 1'b1;
    end

    // Encode temperature as sign-magnitude; minus 128 has no 7-bit magnitude
    always_comb
    begin
        temp_mag = 8'd0 - temperature_c;
        if (!temperature_valid)
        begin
            temp_code = TEMP_ERROR;
        end
        else if (temperature_c[7])
        begin
            temp_code = temp_mag[7] ? TEMP_ERROR : {1'b1, temp_mag[6:0]};
        end
        else
        begin
            temp_code = temperature_c;
        end
    end

    // Build the queue entry
    always_comb
    begin
        entry.has_sample = vout_sample_valid;
        entry.sum        = sum_next;
        entry.load       = load_current_ua;
        entry.range      = sensor_range;
        entry.supply     = supply_sample_valid ? supply_sample_mv : VOLT_ERROR;
        entry.temp_code  = temp_code;
    end

    // Advance the ring on every accepted valid sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg <= '0;
            sum_reg  <= '0;
            for (int i = 0; i < AVERAGE_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (take && vout_sample_valid)
        begin
            widx_reg           <= widx_next;
            sum_reg            <= sum_next;
            ring_reg[widx_reg] <= vout_sample_mv;
        end
    end

endmodule

@@ src/smc_queue.sv @@
module smc_queue
    import smc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  smc_entry_t wr_data,
    output logic       full,
    input  logic       rd_en,
    output smc_entry_t rd_data,
    output logic       empty
);

    smc_entry_t slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = slot_reg[rptr_reg];

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    // Advance pointers and track fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd_en)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

@@ src/smc_back.sv @@
module smc_back
    import smc_pkg::*;
#(
    parameter int unsigned AVERAGE_DEPTH = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [RES_W-1:0]   resistance,
    input  logic               q_empty,
    input  smc_entry_t         q_data,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic [VOLT_W-1:0]  vout_average_mv,
    output logic [CUR_W-1:0]   corrected_current_ua,
    output logic [RANGE_W-1:0] range_out,
    output logic [VOLT_W-1:0]  supply_out_mv,
    output logic [TEMP_W-1:0]  temperature_code
);

    // Mean by reciprocal multiply: exact for every sum below 2**SUM_W
    localparam int unsigned SHIFT   = SUM_W + 5;
    localparam int unsigned RECIP_W = SHIFT + 1;
    localparam int unsigned PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH);
    localparam int unsigned CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_SCALE = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t             state_reg;
    smc_entry_t         work_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [VOLT_W-1:0]  avg_reg;
    logic [VOLT_W-1:0]  avg_next;
    logic [RES_W-1:0]   res_reg;
    logic [RES_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [RES_W:0]     rem_shift;
    logic               rem_ge;
    logic [DIV_W-1:0]   divider_ua;
    logic [CUR_W-1:0]   corrected;
    logic               out_valid_reg;
    logic               out_free;
    logic [VOLT_W-1:0]  avg_out_reg;
    logic [CUR_W-1:0]   cur_out_reg;
    logic [RANGE_W-1:0] range_out_reg;
    logic [VOLT_W-1:0]  supply_out_reg;
    logic [TEMP_W-1:0]  temp_out_reg;

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign out_free = !out_valid_reg || pop;
    assign avg_next = work_reg.has_sample ? prod_reg[SHIFT +: VOLT_W] : avg_reg;

    // One restoring divide step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        rem_ge    = (rem_shift >= {1'b0, res_reg});
    end

    // Floor the corrected current at zero; zero resistance means no correction
    always_comb
    begin
        divider_ua = (res_reg == '0) ? '0 : quo_reg;
        if ({{(DIV_W-CUR_W){1'b0}}, work_reg.load} > divider_ua)
        begin
            corrected = work_reg.load - divider_ua[CUR_W-1:0];
        end
        else
        begin
            corrected = '0;
        end
    end

    // Sequence one item: mean, scale, divide, deliver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            avg_reg       <= VOLT_ERROR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise on a delivered beat, drop on a pop
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    avg_reg   <= avg_next;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (cnt_reg == LAST_STEP)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                work_reg <= q_data;
                res_reg  <= resistance;
            end
            ST_MUL:
            begin
                prod_reg <= PROD_W'(work_reg.sum) * PROD_W'(RECIP);
            end
            ST_SCALE:
            begin
                quo_reg <= DIV_W'(avg_next) * DIV_W'(MV_TO_UV);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= rem_ge ? RES_W'(rem_shift - {1'b0, res_reg})
                                  : rem_shift[RES_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], rem_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    avg_out_reg    <= avg_reg;
                    cur_out_reg    <= corrected;
                    range_out_reg  <= work_reg.range;
                    supply_out_reg <= work_reg.supply;
                    temp_out_reg   <= work_reg.temp_code;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign empty                = !out_valid_reg;
    assign vout_average_mv      = avg_out_reg;
    assign corrected_current_ua = cur_out_reg;
    assign range_out            = range_out_reg;
    assign supply_out_mv        = supply_out_reg;
    assign temperature_code     = temp_out_reg;

endmodule

@@ src/supply_measurement_conditioner.sv @@
// Supply measurement conditioner. Each pushed beat is one measurement set and
// yields one result beat, in order. A valid output-voltage sample enters a ring
// of AVERAGE_DEPTH entries (cleared at reset); the reported average is the
// truncated mean of the whole ring and reads 0xFFFF until the first valid
// sample. The load current is reduced by average * 1000 / divider resistance
// and floored at zero; a resistance of zero disables the correction. Supply
// reads 0xFFFF when invalid; temperature is sign-magnitude, 0x7F on error or
// for -128. The back end takes one item at a time through the 26-step
// restoring divider; a two-entry queue lets the front keep accepting beats
// meanwhile. Write the resistance only while the block is idle.
module supply_measurement_conditioner
    import smc_pkg::*;
#(
    parameter int unsigned AVERAGE_DEPTH = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RES_W-1:0]   cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [VOLT_W-1:0]  vout_sample_mv,
    input  logic               vout_sample_valid,
    input  logic [CUR_W-1:0]   load_current_ua,
    input  logic [RANGE_W-1:0] sensor_range,
    input  logic [VOLT_W-1:0]  supply_sample_mv,
    input  logic               supply_sample_valid,
    input  logic [TEMP_W-1:0]  temperature_c,
    input  logic               temperature_valid,
    output logic               empty,
    input  logic               pop,
    output logic [VOLT_W-1:0]  vout_average_mv,
    output logic [CUR_W-1:0]   corrected_current_ua,
    output logic [RANGE_W-1:0] range_out,
    output logic [VOLT_W-1:0]  supply_out_mv,
    output logic [TEMP_W-1:0]  temperature_code
);

    logic [RES_W-1:0] res_reg;
    logic             take;
    smc_entry_t       front_entry;
    smc_entry_t       q_data;
    logic             q_empty;
    logic             q_pop;

    assign cfg_ready = 1'b1;
    assign take      = push && !full;

    // Hold the divider resistance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= RESISTANCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            res_reg <= cfg_data;
        end
    end

    smc_front #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .take                (take),
        .vout_sample_mv      (vout_sample_mv),
        .vout_sample_valid   (vout_sample_valid),
        .load_current_ua     (load_current_ua),
        .sensor_range        (sensor_range),
        .supply_sample_mv    (supply_sample_mv),
        .supply_sample_valid (supply_sample_valid),
        .temperature_c       (temperature_c),
        .temperature_valid   (temperature_valid),
        .entry               (front_entry)
    );

    smc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (front_entry),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    smc_back #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .resistance           (res_reg),
        .q_empty              (q_empty),
        .q_data               (q_data),
        .q_pop                (q_pop),
        .empty                (empty),
        .pop                  (pop),
        .vout_average_mv      (vout_average_mv),
        .corrected_current_ua (corrected_current_ua),
        .range_out            (range_out),
        .supply_out_mv        (supply_out_mv),
        .temperature_code     (temperature_code)
    );

endmodule

@@ src/smc_checker.sv @@
module smc_checker
    import smc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic [VOLT_W-1:0]  vout_average_mv,
    input logic [CUR_W-1:0]   corrected_current_ua,
    input logic [RANGE_W-1:0] range_out,
    input logic [VOLT_W-1:0]  supply_out_mv,
    input logic [TEMP_W-1:0]  temperature_code
);

    // A waiting result beat stays until popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result beat dropped before pop");

    // A stalled result beat keeps its payload
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(vout_average_mv) && $stable(corrected_current_ua)
            && $stable(range_out) && $stable(supply_out_mv) && $stable(temperature_code))
        else $error("stalled result beat changed");

    // Input side fills only through accepted beats
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        !full && !push |=> !full)
        else $error("queue filled without a push");

    // Sign-magnitude never shows negative zero
    a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> temperature_code != 8'h80)
        else $error("negative zero temperature code");

endmodule

bind supply_measurement_conditioner smc_checker u_smc_checker (.*);
